/* hdl/gpcm_pkg.sv */
// Shared types, constants and arithmetic helpers for the gamma phase compare map.
package gpcm_pkg;

    localparam int LANES       = 4;
    localparam int LEVEL_W     = 10;
    localparam int COMPARE_W   = 11;
    localparam int CODE_W      = 3;
    localparam int PROFILE_W   = 2 * LEVEL_W + CODE_W;
    localparam int CFG_IDX_W   = 4;
    localparam int PROD_W      = 2 * LEVEL_W + 1;

    localparam logic [LEVEL_W-1:0]   FULL_SCALE    = 10'd1023;
    localparam logic [LEVEL_W-1:0]   HALF_SCALE    = 10'd511;
    localparam logic [COMPARE_W-1:0] NEVER_FIRE    = 11'd1024;
    localparam logic [PROFILE_W-1:0] PROFILE_RESET = 23'd1047552;

    // Lane pipeline: stage 0 takes the level, stages 1..LEVEL_W resolve one root bit
    // each, then the curve select, the zone multiply and the final subtract.
    localparam int ST_SHAPE    = LEVEL_W + 1;
    localparam int ST_MUL      = LEVEL_W + 2;
    localparam int ST_FIN      = LEVEL_W + 3;
    localparam int LANE_STAGES = ST_FIN + 1;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    typedef enum logic [CODE_W-1:0] {
        CURVE_LINEAR = 3'd0,
        CURVE_G05    = 3'd1,
        CURVE_G07    = 3'd2,
        CURVE_G15    = 3'd3,
        CURVE_G20    = 3'd4,
        CURVE_G25    = 3'd5,
        CURVE_G30    = 3'd6,
        CURVE_LIN_B  = 3'd7
    } t_curve;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [LEVEL_W-1:0] zone_max;
        logic [LEVEL_W-1:0] zone_min;
    } t_profile;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_lane0;
        logic [LEVEL_W-1:0] level_lane1;
        logic [LEVEL_W-1:0] level_lane2;
        logic [LEVEL_W-1:0] level_lane3;
    } t_in;

    typedef struct packed {
        logic [COMPARE_W-1:0] compare_lane0;
        logic [COMPARE_W-1:0] compare_lane1;
        logic [COMPARE_W-1:0] compare_lane2;
        logic [COMPARE_W-1:0] compare_lane3;
    } t_out;

    // Floor of p / 1023 for p below 1023 * 1024: p >> 10 is short by at most one.
    function automatic logic [LEVEL_W-1:0] div_full(input logic [PROD_W-1:0] p);
        logic [LEVEL_W:0]   q;
        logic [LEVEL_W+1:0] r;
        q = p[PROD_W-1:LEVEL_W];
        r = (LEVEL_W+2)'(p[LEVEL_W-1:0]) + (LEVEL_W+2)'(q);
        if (r >= (LEVEL_W+2)'(FULL_SCALE)) begin
            q = q + 1'b1;
        end
        return q[LEVEL_W-1:0];
    endfunction

    // Rounded product of two full-scale values, scaled back to full scale.
    function automatic logic [LEVEL_W-1:0] scaled_mul(input logic [LEVEL_W-1:0] a,
                                                      input logic [LEVEL_W-1:0] b);
        logic [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'(b) + PROD_W'(HALF_SCALE);
        return div_full(p);
    endfunction

endpackage

/* hdl/gamma_phase_compare_map.sv */
// Top level of the gamma phase compare map: four curve lanes and a merging output register.
//
//  Channel   Direction  Handshake             Payload
//  input     in         i_valid / o_stall     i_in  (t_in,  four 10-bit levels)
//  output    out        o_valid / i_stall     o_out (t_out, four 11-bit compares)
//  config    in         i_cfg_we              i_cfg_index, i_cfg_data (23 bits)
//
// One transaction is taken per cycle while o_stall is low; its result passes the lane stages and the output register.
// The depth is set by the square root search, one root bit per lane stage.
// Synchronous active-low reset empties the pipeline and restores linear full-range profiles.
// A stalled output only stalls the input once every pipeline stage holds a transaction.
module gamma_phase_compare_map
    import gpcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROFILE_W-1:0] i_cfg_data
);

    t_profile               profile [LANES];
    logic [PIPE_STAGES-1:0] load;
    logic [LEVEL_W-1:0]     level   [LANES];
    logic [COMPARE_W-1:0]   compare [LANES];
    t_out                   r_out;

    gpcm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_profile   (profile)
    );

    gpcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_load  (load)
    );

    assign level[0] = i_in.level_lane0;
    assign level[1] = i_in.level_lane1;
    assign level[2] = i_in.level_lane2;
    assign level[3] = i_in.level_lane3;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        gpcm_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (load[LANE_STAGES-1:0]),
            .i_level   (level[i]),
            .i_profile (profile[i]),
            .o_compare (compare[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (load[PIPE_STAGES-1]) begin
            r_out.compare_lane0 <= compare[0];
            r_out.compare_lane1 <= compare[1];
            r_out.compare_lane2 <= compare[2];
            r_out.compare_lane3 <= compare[3];
        end
    end

    assign o_out = r_out;

endmodule

/* hdl/gpcm_cfg.sv */
// Per-lane profile registers written through the configuration port.
module gpcm_cfg
    import gpcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROFILE_W-1:0] i_cfg_data,
    output t_profile             o_profile [LANES]
);

    t_profile r_profile [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANES; i++) begin
                r_profile[i] <= t_profile'(PROFILE_RESET);
            end
        end else begin
            for (int i = 0; i < LANES; i++) begin
                if (i_cfg_we && (i_cfg_index == CFG_IDX_W'(i))) begin
                    r_profile[i] <= t_profile'(i_cfg_data);
                end
            end
        end
    end

    assign o_profile = r_profile;

endmodule

/* hdl/gpcm_ctrl.sv */
// Valid tracking and stage load enables for the lane pipeline and output register.
module gpcm_ctrl
    import gpcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_stall,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [PIPE_STAGES-1:0] o_load
);

    localparam logic [PIPE_STAGES-1:0] ALL_ONES = {PIPE_STAGES{1'b1}};

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] n_valid;
    logic [PIPE_STAGES-1:0] ready;
    logic                   acc_in;
    logic                   acc_out;

    // A stage may load when any stage at or after it is empty, or the output drains,
    // so bubbles close up even while the output is stalled.
    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            ready[k] = (((~r_valid) & (ALL_ONES << k)) != '0) || !i_stall;
        end
        n_valid[0] = ready[0] ? i_valid : r_valid[0];
        for (int k = 1; k < PIPE_STAGES; k++) begin
            n_valid[k] = ready[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_load  = ready;
    assign o_stall = !ready[0];
    assign o_valid = r_valid[PIPE_STAGES-1];
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = o_valid && !i_stall;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> (r_valid == '0))
        else $error("pipeline not empty after reset");

    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_valid) ==
                     $past($countones(r_valid)) + $past(acc_in) - $past(acc_out)))
        else $error("transaction lost or duplicated in pipeline");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && i_stall) |-> (o_load == '0))
        else $error("stage loaded while pipeline full and stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_valid[0] && i_stall))
        else $error("input stalled without a full pipeline");

endmodule

/* hdl/gpcm_lane.sv */
// One lane: gamma curve, zone scaling and compare value, pipelined one root bit a stage.
module gpcm_lane
    import gpcm_pkg::*;
(
    input  logic                   i_clk,
    input  logic [LANE_STAGES-1:0] i_load,
    input  logic [LEVEL_W-1:0]     i_level,
    input  t_profile               i_profile,
    output logic [COMPARE_W-1:0]   o_compare
);

    logic [LEVEL_W-1:0]   r_x    [0:LEVEL_W];
    logic                 r_zero [0:ST_MUL];
    logic [LEVEL_W-1:0]   r_sq   [1:LEVEL_W];
    logic [LEVEL_W-1:0]   r_cu   [2:LEVEL_W];
    logic [LEVEL_W-1:0]   r_root [1:LEVEL_W];
    logic [LEVEL_W-1:0]   r_shaped;
    logic [PROD_W-1:0]    r_prod;
    logic [COMPARE_W-1:0] r_cmp;

    logic [LEVEL_W-1:0]   n_shaped;
    logic [LEVEL_W-1:0]   zone_span;
    logic [LEVEL_W:0]     zoned;
    logic [LEVEL_W:0]     sum_root;
    logic [LEVEL_W:0]     sum_sq;
    logic [LEVEL_W:0]     sum_cu;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_x[0]    <= i_level;
            r_zero[0] <= (i_level == '0);
        end
    end

    // Square root search: each stage tries the next lower bit of the root.
    for (genvar k = 1; k <= LEVEL_W; k++) begin : g_root
        localparam int BIT = LEVEL_W - k;
        logic [LEVEL_W-1:0] root_in;
        logic [LEVEL_W-1:0] cand;

        if (k == 1) begin : g_first
            assign root_in = '0;
        end else begin : g_next
            assign root_in = r_root[k-1];
        end
        assign cand = root_in | (LEVEL_W'(1) << BIT);

        always_ff @(posedge i_clk) begin
            if (i_load[k]) begin
                r_x[k]    <= r_x[k-1];
                r_zero[k] <= r_zero[k-1];
                r_root[k] <= (scaled_mul(cand, cand) <= r_x[k-1]) ? cand : root_in;
            end
        end

        if (k == 1) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (i_load[k]) begin
                    r_sq[k] <= scaled_mul(r_x[k-1], r_x[k-1]);
                end
            end
        end else begin : g_sq_carry
            always_ff @(posedge i_clk) begin
                if (i_load[k]) begin
                    r_sq[k] <= r_sq[k-1];
                end
            end
        end

        if (k == 2) begin : g_cu
            always_ff @(posedge i_clk) begin
                if (i_load[k]) begin
                    r_cu[k] <= scaled_mul(r_sq[k-1], r_x[k-1]);
                end
            end
        end else if (k > 2) begin : g_cu_carry
            always_ff @(posedge i_clk) begin
                if (i_load[k]) begin
                    r_cu[k] <= r_cu[k-1];
                end
            end
        end
    end

    always_comb begin
        sum_root = (LEVEL_W+1)'(r_root[LEVEL_W]) + (LEVEL_W+1)'(r_x[LEVEL_W]) + 1'b1;
        sum_sq   = (LEVEL_W+1)'(r_x[LEVEL_W]) + (LEVEL_W+1)'(r_sq[LEVEL_W]) + 1'b1;
        sum_cu   = (LEVEL_W+1)'(r_sq[LEVEL_W]) + (LEVEL_W+1)'(r_cu[LEVEL_W]) + 1'b1;
        case (t_curve'(i_profile.code))
            CURVE_G05: n_shaped = r_root[LEVEL_W];
            CURVE_G07: n_shaped = sum_root[LEVEL_W:1];
            CURVE_G15: n_shaped = sum_sq[LEVEL_W:1];
            CURVE_G20: n_shaped = r_sq[LEVEL_W];
            CURVE_G25: n_shaped = sum_cu[LEVEL_W:1];
            CURVE_G30: n_shaped = r_cu[LEVEL_W];
            default:   n_shaped = r_x[LEVEL_W];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load[ST_SHAPE]) begin
            r_shaped         <= n_shaped;
            r_zero[ST_SHAPE] <= r_zero[LEVEL_W];
        end
    end

    assign zone_span = i_profile.zone_max - i_profile.zone_min;

    always_ff @(posedge i_clk) begin
        if (i_load[ST_MUL]) begin
            r_prod         <= PROD_W'(zone_span) * PROD_W'(r_shaped) + PROD_W'(HALF_SCALE);
            r_zero[ST_MUL] <= r_zero[ST_SHAPE];
        end
    end

    assign zoned = (LEVEL_W+1)'(i_profile.zone_min) + (LEVEL_W+1)'(div_full(r_prod));

    // An empty or inverted zone pins the zoned level at its max, whatever the curve.
    always_ff @(posedge i_clk) begin
        if (i_load[ST_FIN]) begin
            if (r_zero[ST_MUL]) begin
                r_cmp <= NEVER_FIRE;
            end else if (i_profile.zone_max <= i_profile.zone_min) begin
                r_cmp <= COMPARE_W'(FULL_SCALE) - COMPARE_W'(i_profile.zone_max);
            end else begin
                r_cmp <= COMPARE_W'(FULL_SCALE) - COMPARE_W'(zoned);
            end
        end
    end

    assign o_compare = r_cmp;

endmodule
